// ===== sv/vlip_pkg.sv =====
// ============================================================================
// vlip_pkg
// Shared constants and the first-byte length classifier of the predecoder.
// ============================================================================
package vlip_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned EXT_W      = 24;
    localparam int unsigned WORD_BYTES = WORD_W / BYTE_W;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_len;

    // Opcodes that are decoded as single values
    localparam t_byte OP_CB = 8'hcb;
    localparam t_byte OP_CC = 8'hcc;
    localparam t_byte OP_CD = 8'hcd;
    localparam t_byte OP_DC = 8'hdc;
    localparam t_byte OP_DE = 8'hde;
    localparam t_byte OP_DF = 8'hdf;
    localparam t_byte OP_F0 = 8'hf0;
    localparam t_byte OP_F6 = 8'hf6;
    localparam t_byte OP_F8 = 8'hf8;
    localparam t_byte OP_F9 = 8'hf9;
    localparam t_byte OP_FA = 8'hfa;
    localparam t_byte OP_FB = 8'hfb;
    localparam t_byte OP_FC = 8'hfc;
    localparam t_byte OP_FD = 8'hfd;

    // Masks for the pattern groups
    localparam t_byte MASK_HI = 8'hf0;
    localparam t_byte MASK_M3 = 8'hf3;
    localparam t_byte MASK_MC = 8'hfc;

    // Length in bytes from the first byte; anything unmatched is 7 bytes.
    function automatic t_len length_of_first(input t_byte b);
        t_byte hi;
        t_byte m3;
        t_byte mc;
        logic  reg_pair;
        logic  pair_diff;
        logic  is_one;
        logic  is_two;
        logic  is_three;
        hi        = b & MASK_HI;
        m3        = b & MASK_M3;
        mc        = b & MASK_MC;
        reg_pair  = (hi == 8'h80) || (hi == 8'h90) || (hi == 8'ha0) || (hi == 8'hb0);
        pair_diff = (b[3:2] != b[1:0]);
        is_one    = (m3 == 8'h00) || (hi == 8'h10) || (mc == 8'h3c) || (m3 == 8'h41) ||
                    (m3 == 8'h40) || (mc == 8'h50) || (mc == 8'h54) || (hi == 8'h60) ||
                    (hi == 8'h70) || (reg_pair && pair_diff) || (b == OP_CB) ||
                    (mc == 8'hd0) || (mc == 8'hd4) || (mc == 8'hd8) || (hi == 8'he0);
        is_two    = reg_pair || (mc == 8'h20) || (mc == 8'h28) || (m3 == 8'h43) ||
                    (m3 == 8'h42) || (mc == 8'h58) || (mc == 8'h5c) ||
                    ((hi == 8'hc0) && (b != OP_CB) && (b != OP_CC) && (b != OP_CD)) ||
                    ((b >= OP_F0) && (b <= OP_F6));
        is_three  = (b == OP_F8) || (b == OP_CC) || (b == OP_F9) || (m3 == 8'h01) ||
                    (m3 == 8'h02) || (m3 == 8'h03) || (mc == 8'h24) || (mc == 8'h2c) ||
                    (mc == 8'h30) || (mc == 8'h34) || (mc == 8'h38) || (b == OP_DE) ||
                    (b == OP_DF);
        if (is_one) begin
            return 3'd1;
        end else if (is_two) begin
            return 3'd2;
        end else if (is_three) begin
            return 3'd3;
        end else if ((b == OP_FA) || (b == OP_FB)) begin
            return 3'd4;
        end else if ((b == OP_CD) || (b == OP_DC)) begin
            return 3'd5;
        end else if ((b == OP_FD) || (b == OP_FC)) begin
            return 3'd6;
        end
        return 3'd7;
    endfunction

endpackage

// ===== sv/variable_length_insn_predecoder_unit.sv =====
// ============================================================================
// variable_length_insn_predecoder_unit
// Gathers a code byte stream into variable-length instructions (1..7 bytes).
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one code byte per request
//   together with a fetch-fault flag. Output channel (o_out_valid /
//   i_out_stall) carries one request per finished instruction or fault.
//   The first byte of an instruction picks its length from a masked-compare
//   classifier. Bytes one to four go big-endian into o_insn_word, bytes five
//   to seven into o_extension_bits.
//   Throughput: one byte per cycle while o_in_stall is low. The byte that
//   completes an instruction (or a faulted byte) shows its result on the output
//   in the next cycle; all work sits between the gather and output registers.
//   A fault drops the partial instruction and reports length 0, flag 1.
//   Receiver stall: the output register holds its request; a new byte is
//   still taken in the cycle the held request leaves. While a request is
//   held and stalled, o_in_stall is high.
//   Reset (synchronous, i_rst_n low) clears the gather state and the output
//   valid; the first byte after reset starts a new instruction.
// ============================================================================
module variable_length_insn_predecoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vlip_pkg::BYTE_W-1:0]   i_code_byte,
    input  logic                          i_fetch_fault,
    // instruction output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vlip_pkg::WORD_W-1:0]   o_insn_word,
    output logic [vlip_pkg::EXT_W-1:0]    o_extension_bits,
    output logic [vlip_pkg::CNT_W-1:0]    o_insn_length,
    output logic                          o_fault_flag
);
    import vlip_pkg::*;

    // gather state
    t_len              r_cnt, n_cnt;
    t_len              r_len, n_len;
    logic [WORD_W-1:0] r_word, n_word;
    logic [EXT_W-1:0]  r_ext, n_ext;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    logic [EXT_W-1:0]  r_out_ext, n_out_ext;
    t_len              r_out_len, n_out_len;
    logic              r_out_fault, n_out_fault;

    logic in_accept;
    logic emit;
    t_len first_len;

    // output slot frees up when it is empty or drains this cycle
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign first_len  = length_of_first(i_code_byte);

    always_comb begin
        t_len cnt_inc;
        t_len len_sel;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_word      = r_word;
        n_ext       = r_ext;
        n_out_word  = r_out_word;
        n_out_ext   = r_out_ext;
        n_out_len   = r_out_len;
        n_out_fault = r_out_fault;
        emit        = 1'b0;
        cnt_inc     = r_cnt + 3'd1;
        len_sel     = r_len;
        if (in_accept) begin
            if (i_fetch_fault) begin
                // abort: drop partial, report the fault
                emit        = 1'b1;
                n_cnt       = '0;
                n_len       = '0;
                n_word      = '0;
                n_ext       = '0;
                n_out_word  = '0;
                n_out_ext   = '0;
                n_out_len   = '0;
                n_out_fault = 1'b1;
            end else begin
                if (r_cnt == '0) begin
                    len_sel = first_len;
                    n_word  = {{(WORD_W-BYTE_W){1'b0}}, i_code_byte};
                    n_ext   = '0;
                    cnt_inc = 3'd1;
                end else if (r_cnt < t_len'(WORD_BYTES)) begin
                    n_word  = {r_word[WORD_W-BYTE_W-1:0], i_code_byte};
                end else begin
                    n_ext   = {r_ext[EXT_W-BYTE_W-1:0], i_code_byte};
                end
                n_len = len_sel;
                n_cnt = cnt_inc;
                if (cnt_inc >= len_sel) begin
                    emit        = 1'b1;
                    n_out_word  = n_word;
                    n_out_ext   = n_ext;
                    n_out_len   = len_sel;
                    n_out_fault = 1'b0;
                    n_cnt       = '0;
                    n_len       = '0;
                    n_word      = '0;
                    n_ext       = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_len       <= '0;
            r_word      <= '0;
            r_ext       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_len  <= n_len;
            r_word <= n_word;
            r_ext  <= n_ext;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_out_ext   <= n_out_ext;
        r_out_len   <= n_out_len;
        r_out_fault <= n_out_fault;
    end

    assign o_out_valid      = r_out_valid;
    assign o_insn_word      = r_out_word;
    assign o_extension_bits = r_out_ext;
    assign o_insn_length    = r_out_len;
    assign o_fault_flag     = r_out_fault;

    // a fault always restarts gathering
    a_fault_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_fetch_fault) |=> (r_cnt == '0))
        else $error("gather count not cleared after fault");

    // mid-instruction count stays below the chosen length
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_cnt < r_len))
        else $error("gather count reached length without emitting");

    // fault result reports zero length, good result a nonzero one
    a_len_vs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault_flag == (o_insn_length == '0)))
        else $error("length and fault flag disagree");

    // a one-byte opcode at the start yields a result next cycle
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_fetch_fault && (r_cnt == '0) && (first_len == 3'd1))
        |=> (o_out_valid && (o_insn_length == 3'd1)))
        else $error("single-byte instruction not emitted");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the variable-length instruction predecoder: a
// byte stream with random faults goes in through a random-idle driver,
// results are checked one by one against an in-bench instruction predictor.
// ============================================================================
module tb_top;

    import vlip_pkg::*;

    localparam int RANDOM_BYTES = 1350;
    localparam int IDLE_PCT     = 12;
    localparam int HANG_LIMIT   = 2000;  // cycles with work pending and no handshake
    localparam int DRAIN_CYCLES = 8;     // result shows in the cycle after its byte is taken

    // one code byte request
    typedef struct packed {
        t_byte code;
        logic  fault;
    } t_code_req;

    // one instruction result as the block should report it
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [EXT_W-1:0]  ext;
        t_len              len;
        logic              fault;
    } t_insn_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_code_byte;
    logic              i_fetch_fault;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [WORD_W-1:0] o_insn_word;
    logic [EXT_W-1:0]  o_extension_bits;
    logic [CNT_W-1:0]  o_insn_length;
    logic              o_fault_flag;

    variable_length_insn_predecoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_byte      (i_code_byte),
        .i_fetch_fault    (i_fetch_fault),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_insn_word      (o_insn_word),
        .o_extension_bits (o_extension_bits),
        .o_insn_length    (o_insn_length),
        .o_fault_flag     (o_fault_flag)
    );

    t_code_req code_feed[$];       // bytes still to be presented
    t_insn_res expected_insns[$];  // results predicted but not yet seen

    // predictor copy of the gather state
    t_len              pd_got;
    t_len              pd_want;
    logic [WORD_W-1:0] pd_word;
    logic [EXT_W-1:0]  pd_ext;

    t_code_req  next_req;
    t_insn_res  seen_res;
    t_insn_res  want_res;
    logic       byte_taken;
    logic       calm;          // no idling on either side while set
    int         n_bytes;
    int         n_results;
    int         n_faults;
    int         n_fail;
    int         hang_cnt;
    int         len_seen[8];

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Length classifier, from the first byte of an instruction
    // ------------------------------------------------------------------
    function automatic t_len opcode_length(input t_byte op);
        logic [3:0] nib;
        logic       reg_pair;
        logic       pair_ne;
        logic       len1;
        logic       len2;
        logic       len3;
        nib      = op[7:4];
        reg_pair = (op[7:6] == 2'b10);          // 0x80 .. 0xbf
        pair_ne  = (op[3:2] != op[1:0]);
        len1 = (nib == 4'h0 && op[1:0] == 2'b00) || nib == 4'h1 ||
               (op >= 8'h3c && op <= 8'h3f) ||
               ((op & 8'hf2) == 8'h40) ||       // 40/41 under the f3 mask
               (op >= 8'h50 && op <= 8'h57) || nib == 4'h6 || nib == 4'h7 ||
               (reg_pair && pair_ne) || op == 8'hcb ||
               (op >= 8'hd0 && op <= 8'hdb) || nib == 4'he;
        len2 = reg_pair || (op >= 8'h20 && op <= 8'h23) ||
               (op >= 8'h28 && op <= 8'h2b) || ((op & 8'hf2) == 8'h42) ||
               (op >= 8'h58 && op <= 8'h5f) ||
               (nib == 4'hc && op != 8'hcb && op != 8'hcc && op != 8'hcd) ||
               (op >= 8'hf0 && op <= 8'hf6);
        len3 = op == 8'hf8 || op == 8'hcc || op == 8'hf9 ||
               (nib == 4'h0 && op[1:0] != 2'b00) ||
               (op >= 8'h24 && op <= 8'h27) || (op >= 8'h2c && op <= 8'h3b) ||
               op == 8'hde || op == 8'hdf;
        if (len1) begin
            return 3'd1;
        end else if (len2) begin
            return 3'd2;
        end else if (len3) begin
            return 3'd3;
        end else if (op == 8'hfa || op == 8'hfb) begin
            return 3'd4;
        end else if (op == 8'hcd || op == 8'hdc) begin
            return 3'd5;
        end else if (op == 8'hfc || op == 8'hfd) begin
            return 3'd6;
        end
        return 3'd7;    // no pattern matched
    endfunction

    // Advance the predicted gather state by one accepted byte request.
    task automatic predecode_byte(input t_byte b, input logic flt);
        if (flt) begin
            // a fault drops whatever was gathered, even when nothing was
            expected_insns.push_back('{word: '0, ext: '0, len: 3'd0, fault: 1'b1});
            pd_got  = '0;
            pd_want = '0;
            pd_word = '0;
            pd_ext  = '0;
        end else begin
            if (pd_got == 3'd0) begin
                pd_want = opcode_length(b);
                pd_word = {24'h0, b};
                pd_ext  = '0;
                pd_got  = 3'd1;
            end else begin
                if (pd_got < 3'd4) begin
                    pd_word = {pd_word[23:0], b};
                end else begin
                    pd_ext = {pd_ext[15:0], b};
                end
                pd_got = pd_got + 3'd1;
            end
            // a one-byte instruction completes right here
            if (pd_got >= pd_want) begin
                expected_insns.push_back('{word: pd_word, ext: pd_ext,
                                           len: pd_want, fault: 1'b0});
                pd_got  = '0;
                pd_want = '0;
                pd_word = '0;
                pd_ext  = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $realtime, name, exp_v, act_v);
            n_fail++;
        end
    endtask

    task automatic push_byte(input t_byte b, input logic flt);
        code_feed.push_back('{code: b, fault: flt});
    endtask

    // ------------------------------------------------------------------
    // Driver: new request at the falling edge once the old one is gone.
    // Valid depends on the feed, the calm flag and the idle draw, never on stall.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || byte_taken) begin
                if (code_feed.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_req       = code_feed.pop_front();
                    i_in_valid    <= 1'b1;
                    i_code_byte   <= next_req.code;
                    i_fetch_fault <= next_req.fault;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. The output side
    // is checked first; a result never belongs to a byte taken at the
    // same edge since the block registers its output.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                seen_res = '{word: o_insn_word, ext: o_extension_bits,
                             len: o_insn_length, fault: o_fault_flag};
                if (expected_insns.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %p",
                             $realtime, seen_res);
                    n_fail++;
                end else begin
                    want_res = expected_insns.pop_front();
                    check_field("insn_word", want_res.word, seen_res.word);
                    check_field("extension_bits", 32'(want_res.ext),
                                32'(seen_res.ext));
                    check_field("insn_length", 32'(want_res.len),
                                32'(seen_res.len));
                    check_field("fault_flag", 32'(want_res.fault),
                                32'(seen_res.fault));
                    n_results++;
                    if (want_res.fault) begin
                        n_faults++;
                    end
                    len_seen[want_res.len]++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predecode_byte(i_code_byte, i_fetch_fault);
                n_bytes++;
            end
        end
    end

    // Quiet stretch in the middle of the stream: back-to-back traffic.
    assign calm = (n_bytes >= 500) && (n_bytes < 800);

    // ------------------------------------------------------------------
    // Watchdog: only counts while something is still outstanding
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && (code_feed.size() != 0 || i_in_valid ||
                        expected_insns.size() != 0)) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                hang_cnt <= 0;
            end else if (hang_cnt >= HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, hang_cnt);
                $display("TB_ERROR");
                $finish;
            end else begin
                hang_cnt <= hang_cnt + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int   n_rand;
        int   pick;
        t_byte op;
        t_len  n_len;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_code_byte   = '0;
        i_fetch_fault = 1'b0;
        i_out_stall   = 1'b0;
        byte_taken    = 1'b0;
        pd_got        = '0;
        pd_want       = '0;
        pd_word       = '0;
        pd_ext        = '0;
        n_bytes       = 0;
        n_results     = 0;
        n_faults      = 0;
        n_fail        = 0;
        hang_cnt      = 0;
        n_rand        = 0;
        foreach (len_seen[k]) len_seen[k] = 0;

        // directed: fault with nothing gathered (byte ignored)
        push_byte(8'ha5, 1'b1);
        // one-byte instruction
        push_byte(8'h00, 1'b0);
        // two bytes
        push_byte(8'h80, 1'b0);
        push_byte(8'hff, 1'b0);
        // unmatched first byte, seven bytes, all-ones and all-zeros payload
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        // fault in the middle of a six-byte instruction
        push_byte(8'hfd, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'hff, 1'b1);
        // four and five bytes
        push_byte(8'hfa, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'hcd, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);

        // random: mostly whole instructions with random content, a few
        // faults cutting instructions short and some stray faults between
        while (n_rand < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                push_byte(t_byte'($urandom), 1'b1);
                n_rand++;
            end else begin
                op    = t_byte'($urandom);
                n_len = opcode_length(op);
                for (int k = 0; k < int'(n_len); k++) begin
                    if (k > 0 && $urandom_range(0, 99) < 3) begin
                        push_byte(t_byte'($urandom), 1'b1);
                        n_rand++;
                        break;
                    end
                    push_byte((k == 0) ? op : t_byte'($urandom), 1'b0);
                    n_rand++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain: every byte taken and every result seen
        while (code_feed.size() != 0 || i_in_valid || expected_insns.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results (%0d faults) from %0d code bytes.",
                 n_results, n_faults, n_bytes);
        $display("Lengths 1..7 seen: %0d %0d %0d %0d %0d %0d %0d",
                 len_seen[1], len_seen[2], len_seen[3], len_seen[4],
                 len_seen[5], len_seen[6], len_seen[7]);
        if (n_fail == 0 && expected_insns.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
